FILE: rtl/core/wfe_pkg.sv
// Shared types, constants and helpers for the WebSocket frame encoder.
package wfe_pkg;

    // Frame header constants
    localparam logic [7:0]  FIN_BIT     = 8'h80;
    localparam logic [7:0]  MASK_BIT    = 8'h80;
    localparam logic [6:0]  LEN16_CODE  = 7'd126;
    localparam logic [6:0]  LEN64_CODE  = 7'd127;
    localparam logic [31:0] LEN7_MAX    = 32'd125;
    localparam logic [31:0] LEN16_MAX   = 32'd65535;
    localparam logic [31:0] KEY_RESET   = 32'h12345678;

    // Header sizes: byte index into a header run
    localparam int          HDR_MAX_BYTES = 14;
    localparam int          IDX_W         = $clog2(HDR_MAX_BYTES);
    localparam logic [IDX_W-1:0] KEY_BASE_SHORT = IDX_W'(2);
    localparam logic [IDX_W-1:0] KEY_BASE_LEN16 = IDX_W'(4);
    localparam logic [IDX_W-1:0] KEY_BASE_LEN64 = IDX_W'(10);
    localparam logic [IDX_W-1:0] KEY_BYTES      = IDX_W'(4);

    // Depth of the request queue between front and back
    localparam int          QUEUE_DEPTH_DEF = 4;

    // Kind of a queued request
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_REFUSE  = 2'd1,
        KIND_HEADER  = 2'd2
    } kind_t;

    // Length encoding of a header
    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_16    = 2'd1,
        LEN_64    = 2'd2
    } len_class_t;

    // One classified request, passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;       // masked payload byte
        logic        last;       // payload byte ends the frame
        logic [3:0]  opcode;
        logic [31:0] length;
        logic        client;
        len_class_t  len_class;
    } desc_t;

    // Key byte 0 sits in the most significant byte
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/wfe_front.sv
// Front part: accepts requests, tracks masking state and classifies headers.
module wfe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         key_word,
    input  logic                in_valid,
    input  logic                in_command,
    input  logic [3:0]          in_opcode,
    input  logic [31:0]         in_length,
    input  logic                in_client,
    input  logic                in_link_open,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                q_full,
    output logic                q_push,
    output wfe_pkg::desc_t      q_desc
);
    import wfe_pkg::*;

    logic       masking_on_reg, masking_on_next;
    logic [1:0] key_pos_reg, key_pos_next;
    logic [7:0] key_mask;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign key_mask = masking_on_reg ? key_byte(key_word, key_pos_reg) : 8'h00;

    // Classify the request and build the queue entry
    always_comb begin
        q_desc          = '0;
        q_desc.data     = in_byte ^ key_mask;
        q_desc.last     = in_last;
        q_desc.opcode   = in_opcode;
        q_desc.length   = in_length;
        q_desc.client   = in_client;
        if (in_length <= LEN7_MAX) begin
            q_desc.len_class = LEN_SHORT;
        end else if (in_length <= LEN16_MAX) begin
            q_desc.len_class = LEN_16;
        end else begin
            q_desc.len_class = LEN_64;
        end
        if (in_command) begin
            q_desc.kind = KIND_PAYLOAD;
        end else if (!in_link_open) begin
            q_desc.kind = KIND_REFUSE;
        end else begin
            q_desc.kind = KIND_HEADER;
        end
    end

    // Advance masking state on each accepted request
    always_comb begin
        masking_on_next = masking_on_reg;
        key_pos_next    = key_pos_reg;
        if (q_push) begin
            if (in_command) begin
                key_pos_next = in_last ? 2'd0 : key_pos_reg + 2'd1;
            end else begin
                masking_on_next = in_link_open && in_client;
                key_pos_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            masking_on_reg <= 1'b0;
            key_pos_reg    <= 2'd0;
        end else begin
            masking_on_reg <= masking_on_next;
            key_pos_reg    <= key_pos_next;
        end
    end

endmodule

FILE: rtl/core/wfe_queue.sv
// Request queue between the front and back parts.
module wfe_queue #(
    parameter int DEPTH = wfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wfe_pkg::desc_t  push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output wfe_pkg::desc_t  head_desc
);
    import wfe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    desc_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_MAX);
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: rtl/core/wfe_back.sv
// Back part: expands queued requests into output bytes, one per cycle while out_ready is high.
module wfe_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [31:0]     key_word,
    input  logic            head_valid,
    input  wfe_pkg::desc_t  head_desc,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_run_last,
    output logic            out_frame_end,
    output logic            out_refused
);
    import wfe_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] key_base, n_bytes, key_idx;
    logic [7:0]       len_code, hdr_byte;
    logic [7:0]       byte_c;
    logic             last_c, fend_c, refd_c;
    logic             load;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg, fend_reg, refd_reg;

    // Header layout for the head request
    always_comb begin
        case (head_desc.len_class)
            LEN_SHORT: begin
                key_base = KEY_BASE_SHORT;
                len_code = {1'b0, head_desc.length[6:0]};
            end
            LEN_16: begin
                key_base = KEY_BASE_LEN16;
                len_code = {1'b0, LEN16_CODE};
            end
            default: begin
                key_base = KEY_BASE_LEN64;
                len_code = {1'b0, LEN64_CODE};
            end
        endcase
        n_bytes = head_desc.client ? key_base + KEY_BYTES : key_base;
        key_idx = idx_reg - key_base;
    end

    // Select the header byte at the current index
    always_comb begin
        hdr_byte = 8'h00;
        if (idx_reg >= key_base) begin
            hdr_byte = key_byte(key_word, key_idx[1:0]);
        end else if (idx_reg == IDX_W'(0)) begin
            hdr_byte = FIN_BIT | {4'h0, head_desc.opcode};
        end else if (idx_reg == IDX_W'(1)) begin
            hdr_byte = len_code | (head_desc.client ? MASK_BIT : 8'h00);
        end else if (head_desc.len_class == LEN_16) begin
            hdr_byte = (idx_reg == IDX_W'(2)) ? head_desc.length[15:8]
                                              : head_desc.length[7:0];
        end else begin
            case (idx_reg)
                IDX_W'(6): hdr_byte = head_desc.length[31:24];
                IDX_W'(7): hdr_byte = head_desc.length[23:16];
                IDX_W'(8): hdr_byte = head_desc.length[15:8];
                IDX_W'(9): hdr_byte = head_desc.length[7:0];
                default:   hdr_byte = 8'h00;
            endcase
        end
    end

    // Result fields for the head request
    always_comb begin
        case (head_desc.kind)
            KIND_PAYLOAD: begin
                byte_c = head_desc.data;
                last_c = 1'b1;
                fend_c = head_desc.last;
                refd_c = 1'b0;
            end
            KIND_REFUSE: begin
                byte_c = 8'h00;
                last_c = 1'b1;
                fend_c = 1'b0;
                refd_c = 1'b1;
            end
            KIND_HEADER: begin
                byte_c = hdr_byte;
                last_c = (idx_reg == n_bytes - IDX_W'(1));
                fend_c = 1'b0;
                refd_c = 1'b0;
            end
            default: begin
                byte_c = 8'h00;
                last_c = 1'b1;
                fend_c = 1'b0;
                refd_c = 1'b0;
            end
        endcase
    end

    // Load the output register when it is empty or being drained
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && last_c;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = last_c ? '0 : idx_reg + IDX_W'(1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_c;
            last_reg <= last_c;
            fend_reg <= fend_c;
            refd_reg <= refd_c;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_run_last  = last_reg;
    assign out_frame_end = fend_reg;
    assign out_refused   = refd_reg;

endmodule

FILE: rtl/core/websocket_frame_encoder.sv
// Top level of the WebSocket frame encoder: mask key register, front, queue and back.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  command (tuser), header fields or payload byte
//  m_*       out        m_tvalid/m_tready  header byte, masked payload byte or refusal
//  cfg_*     in         cfg_we             mask key, written while idle
//
//  A payload byte or a refused header gives one output byte, one per cycle while m_tready is high.
//  A header gives 2 to 14 bytes, one per cycle from the back part's byte counter while m_tready is high.
//  The request queue lets the input side run ahead while a header is expanded.
//  Reset (aresetn low, synchronous) clears masking, key position, queue and output.
//  m_tready low holds the output register; requests are taken until the queue fills.
module websocket_frame_encoder #(
    parameter int QUEUE_DEPTH = wfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] opcode, [35:4] frame length, [36] client_role, [37] link_open,
    // [45:38] payload_byte, [47:46] zero
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,    // payload_last
    input  logic        s_tuser,    // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic        m_tlast,    // run_last
    output logic [1:0]  m_tuser     // [0] frame_end, [1] refused
);
    import wfe_pkg::*;

    logic [31:0] key_word_reg, key_word_next;
    logic        q_full, q_push, q_pop, q_head_valid;
    desc_t       q_desc, q_head;
    logic        fend, refd;

    // Mask key register
    assign key_word_next = cfg_we ? cfg_wdata : key_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_word_reg <= KEY_RESET;
        end else begin
            key_word_reg <= key_word_next;
        end
    end

    wfe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_word     (key_word_reg),
        .in_valid     (s_tvalid),
        .in_command   (s_tuser),
        .in_opcode    (s_tdata[3:0]),
        .in_length    (s_tdata[35:4]),
        .in_client    (s_tdata[36]),
        .in_link_open (s_tdata[37]),
        .in_byte      (s_tdata[45:38]),
        .in_last      (s_tlast),
        .in_ready     (s_tready),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_desc       (q_desc)
    );

    wfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_desc  (q_head)
    );

    wfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .key_word      (key_word_reg),
        .head_valid    (q_head_valid),
        .head_desc     (q_head),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_run_last  (m_tlast),
        .out_frame_end (fend),
        .out_refused   (refd)
    );

    assign m_tuser = {refd, fend};

`ifndef SYNTHESIS
    // A refusal is a single zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00))
        else $error("refused result is not a lone zero byte");

    // Frame end and refusal never share a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("frame end on a refused result");

    // A frame end byte is the only result of its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end byte not last of its run");

    // The front never offers a request to a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready && !q_push)
        else $error("push into a full queue");
`endif

endmodule

FILE: verif/websocket_frame_encoder_test.sv
// Self-checking testbench for the WebSocket frame encoder: header, refusal and masking checks.
module websocket_frame_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wfe_pkg::*;

    typedef enum logic {
        CMD_HEADER  = 1'b0,
        CMD_PAYLOAD = 1'b1
    } command_t;

    // One request as offered on the input stream
    typedef struct {
        command_t    cmd;
        logic [3:0]  opcode;
        logic [31:0] length;
        logic        client;
        logic        link_up;
        logic [7:0]  pbyte;
        logic        plast;
    } request_t;

    // One byte as it should leave the output stream
    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       refused;
    } frame_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // Encoder state as the testbench sees it
    logic [31:0] key_model = KEY_RESET;
    logic        mask_active = 1'b0;
    logic [1:0]  key_index = '0;
    frame_byte_t pending_bytes[$];

    int unsigned mismatch_count = 0;
    int unsigned requests_sent = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;

    websocket_frame_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Drive receiver readiness: a long hold-off when asked, else random stalls
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Key byte at a given position, byte 0 in the top bits
    function automatic logic [7:0] mask_byte_at(logic [1:0] pos);
        return key_model[8 * (3 - pos) +: 8];
    endfunction

    // Compute the output bytes of one accepted request and advance the state
    function automatic void encode_request(request_t req);
        logic [7:0] hdr[$];
        logic [7:0] b;
        if (req.cmd == CMD_PAYLOAD) begin
            b = req.pbyte;
            if (mask_active)
                b = b ^ mask_byte_at(key_index);
            key_index = req.plast ? 2'd0 : key_index + 2'd1;
            pending_bytes.push_back('{b, 1'b1, req.plast, 1'b0});
            return;
        end
        if (!req.link_up) begin
            mask_active = 1'b0;
            key_index = '0;
            pending_bytes.push_back('{8'h00, 1'b1, 1'b0, 1'b1});
            return;
        end
        hdr.push_back(FIN_BIT | {4'h0, req.opcode});
        if (req.length <= LEN7_MAX) begin
            hdr.push_back(req.length[7:0]);
        end else if (req.length <= LEN16_MAX) begin
            hdr.push_back({1'b0, LEN16_CODE});
            hdr.push_back(req.length[15:8]);
            hdr.push_back(req.length[7:0]);
        end else begin
            hdr.push_back({1'b0, LEN64_CODE});
            repeat (4) hdr.push_back(8'h00);
            hdr.push_back(req.length[31:24]);
            hdr.push_back(req.length[23:16]);
            hdr.push_back(req.length[15:8]);
            hdr.push_back(req.length[7:0]);
        end
        if (req.client) begin
            hdr[1] = hdr[1] | MASK_BIT;
            for (int k = 0; k < 4; k++)
                hdr.push_back(mask_byte_at(2'(k)));
        end
        mask_active = req.client;
        key_index = '0;
        foreach (hdr[i])
            pending_bytes.push_back('{hdr[i], i == hdr.size() - 1, 1'b0, 1'b0});
    endfunction

    // Compare each output byte with the oldest expected one
    always @(posedge aclk) begin : check_output
        frame_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: byte %02h last %0b user %02b with nothing expected",
                             $realtime, m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.out_byte || m_tlast !== want.run_last ||
                    m_tuser[0] !== want.frame_end || m_tuser[1] !== want.refused) begin
                    mismatch_count++;
                    // byte/last/end/refused
                    if (mismatch_count <= 10)
                        $display("%0t: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                                 $realtime, want.out_byte, want.run_last, want.frame_end,
                                 want.refused, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_request(request_t req);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req.cmd;
        s_tlast <= req.plast;
        s_tdata <= {2'b00, req.pbyte, req.link_up, req.client, req.length, req.opcode};
        do @(posedge aclk); while (!s_tready);
        encode_request(req);
        requests_sent++;
    endtask

    // Stop offering and hold until every expected byte has come out
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    task automatic set_mask_key(logic [31:0] key);
        cfg_we <= 1'b1;
        cfg_wdata <= key;
        @(posedge aclk);
        cfg_we <= 1'b0;
        key_model = key;
        @(posedge aclk);
    endtask

    // Random content in every field; callers override what matters
    function automatic request_t noise_request();
        request_t r;
        r.cmd = command_t'($urandom_range(1));
        r.opcode = 4'($urandom_range(15));
        r.length = $urandom();
        r.client = 1'($urandom_range(1));
        r.link_up = 1'($urandom_range(1));
        r.pbyte = 8'($urandom_range(255));
        r.plast = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic request_t header_request(logic [3:0] op, logic [31:0] len,
                                                logic client, logic link_up);
        request_t r;
        r = noise_request();
        r.cmd = CMD_HEADER;
        r.opcode = op;
        r.length = len;
        r.client = client;
        r.link_up = link_up;
        return r;
    endfunction

    function automatic request_t payload_request(logic [7:0] b, logic last);
        request_t r;
        r = noise_request();
        r.cmd = CMD_PAYLOAD;
        r.pbyte = b;
        r.plast = last;
        return r;
    endfunction

    // Short lengths most often, with each length encoding and its boundaries
    function automatic logic [31:0] random_length();
        logic [31:0] edges[7] = '{0, 125, 126, 127, 65535, 65536, 32'hFFFF_FFFF};
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(125);
            4:          return edges[$urandom_range(6)];
            5, 6:       return $urandom_range(65535, 126);
            default:    return $urandom();
        endcase
    endfunction

    // Mostly well-formed frames; the rest refusals, stray bytes and bare headers
    task automatic send_random_sequence();
        request_t hdr;
        int unsigned roll;
        int unsigned count;
        roll = $urandom_range(99);
        if (roll < 70) begin
            hdr = header_request(4'($urandom_range(15)), random_length(),
                                 1'($urandom_range(1)), 1'b1);
            send_request(hdr);
            count = (hdr.length <= 12) ? hdr.length : $urandom_range(12);
            for (int i = 0; i < count; i++)
                send_request(payload_request(8'($urandom_range(255)), i == count - 1));
        end else if (roll < 80) begin
            send_request(header_request(4'($urandom_range(15)), random_length(),
                                        1'($urandom_range(1)), 1'b0));
            repeat ($urandom_range(3))
                send_request(payload_request(8'($urandom_range(255)),
                                             1'($urandom_range(1))));
        end else if (roll < 92) begin
            repeat ($urandom_range(4, 1))
                send_request(payload_request(8'($urandom_range(255)),
                                             1'($urandom_range(1))));
        end else begin
            send_request(header_request(4'($urandom_range(15)), random_length(),
                                        1'($urandom_range(1)), 1'($urandom_range(1))));
        end
    endtask

    // Each length encoding at its edges, refusal, key wrap and stray bytes
    task automatic test_directed_cases();
        idle_pct = 0;
        stall_pct = 0;
        send_request(payload_request(8'hA5, 1'b0));
        send_request(header_request(4'h0, 32'd0, 1'b0, 1'b1));
        send_request(header_request(4'hF, 32'd125, 1'b1, 1'b1));
        send_request(payload_request(8'h00, 1'b0));
        send_request(payload_request(8'hFF, 1'b0));
        send_request(payload_request(8'h5A, 1'b0));
        send_request(payload_request(8'h3C, 1'b0));
        send_request(payload_request(8'h99, 1'b1));
        send_request(payload_request(8'h11, 1'b1));
        send_request(header_request(4'h1, 32'd126, 1'b1, 1'b1));
        send_request(payload_request(8'h7E, 1'b0));
        send_request(header_request(4'h2, 32'd65535, 1'b0, 1'b1));
        send_request(payload_request(8'h81, 1'b1));
        send_request(header_request(4'h8, 32'd65536, 1'b1, 1'b1));
        send_request(header_request(4'h9, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_request(header_request(4'hA, 32'd0, 1'b1, 1'b1));
        send_request(header_request(4'h1, 32'd10, 1'b1, 1'b0));
        send_request(payload_request(8'hC3, 1'b1));
        send_request(header_request(4'hF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_request(payload_request(8'hFF, 1'b1));
        wait_until_drained();
    endtask

    // Masked frames under the all-zero, all-one and a random key
    task automatic test_mask_key_extremes();
        logic [31:0] keys[3];
        int unsigned count;
        keys = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom()};
        foreach (keys[k]) begin
            wait_until_drained();
            set_mask_key(keys[k]);
            repeat (2) begin
                count = $urandom_range(8, 1);
                send_request(header_request(4'($urandom_range(15)), count, 1'b1, 1'b1));
                for (int i = 0; i < count; i++)
                    send_request(payload_request(8'($urandom_range(255)), i == count - 1));
            end
        end
        wait_until_drained();
    endtask

    task automatic test_random_traffic(int unsigned count, int unsigned idle,
                                       int unsigned stall);
        int unsigned stop_at;
        wait_until_drained();
        set_mask_key($urandom());
        idle_pct = idle;
        stall_pct = stall;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
            send_random_sequence();
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        int unsigned stop_at;
        wait_until_drained();
        idle_pct = 0;
        stall_pct = 0;
        hold_left <= 300;
        stop_at = requests_sent + 40;
        while (requests_sent < stop_at)
            send_random_sequence();
    endtask

    // Pause the input until the output has caught up, then resume
    task automatic test_sender_pause();
        idle_pct = 20;
        stall_pct = 20;
        repeat (3) send_random_sequence();
        wait_until_drained();
        repeat (3) send_random_sequence();
        wait_until_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_mask_key_extremes();
        test_random_traffic(75, 0, 0);
        test_random_traffic(75, 88, 0);
        test_random_traffic(75, 0, 88);
        test_random_traffic(75, 27, 27);
        test_output_hold_off();
        test_sender_pause();
        wait_until_drained();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/wfe_pkg.sv
rtl/core/wfe_front.sv
rtl/core/wfe_queue.sv
rtl/core/wfe_back.sv
rtl/core/websocket_frame_encoder.sv
verif/websocket_frame_encoder_test.sv
